@@ rtl/core/u16u8_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16BE to UTF-8 transcoder.
// ---------------------------------------------------------------------------
package u16u8_pkg;

	// limits and reset values
	localparam int          MAX_UNITS        = 512;
	localparam logic [9:0]  BYTE_LIMIT_RESET = 10'd510;

	// code unit classification masks
	localparam logic [15:0] MASK_ONE_BYTE  = 16'hff80;
	localparam logic [15:0] MASK_TWO_BYTE  = 16'hf800;
	localparam logic [15:0] MASK_SURR      = 16'hfc00;
	localparam logic [15:0] HIGH_SURR_BASE = 16'hd800;
	localparam logic [10:0] PLANE_OFFSET   = 11'h040;

	// utf-8 lead and continuation marks
	localparam logic [7:0]  LEAD_TWO  = 8'hc0;
	localparam logic [7:0]  LEAD_THREE = 8'he0;
	localparam logic [7:0]  LEAD_FOUR = 8'hf0;
	localparam logic [7:0]  CONT_MARK = 8'h80;

	// everything one code unit produces, handed from encoder to emitter
	typedef struct packed {
		logic [3:0][7:0] seq;
		logic [2:0]      nbytes;
		logic            summary;
		logic [10:0]     src;
		logic [9:0]      dst;
		logic            status;
	} bundle_t;

endpackage

@@ rtl/core/u16u8_encode.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u16u8_encode
// Per-string state and the encoder that turns one code unit into a bundle
// of up to four UTF-8 bytes plus an optional end-of-string summary.
// ---------------------------------------------------------------------------
module u16u8_encode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          unit,
	input  logic                 last,
	input  logic                 fire,
	input  logic [9:0]           limit,
	output u16u8_pkg::bundle_t   bundle,
	output logic                 has_results
);

	logic [9:0]  pend_bits_q;
	logic        pend_valid_q;
	logic [10:0] src_q;
	logic [9:0]  dst_q;
	logic        halted_q;

	logic [9:0]  pend_bits_n;
	logic        pend_valid_n;
	logic [10:0] src_n;
	logic [9:0]  dst_n;
	logic        halted_n;

	logic [3:0][7:0] seq;
	logic [2:0]  len;
	logic [1:0]  units;
	logic [10:0] hi_off;
	logic [20:0] val;
	logic [10:0] dst_sum;
	logic [12:0] unit_sum;
	logic        no_room;

	// surrogate pair code point
	assign hi_off = {1'b0, pend_bits_q} + u16u8_pkg::PLANE_OFFSET;
	assign val    = {hi_off[10:0], unit[9:0]};

	// encode and next-state
	always_comb begin
		seq          = '0;
		len          = 3'd0;
		units        = 2'd1;
		pend_bits_n  = pend_bits_q;
		pend_valid_n = pend_valid_q;
		src_n        = src_q;
		dst_n        = dst_q;
		halted_n     = halted_q;

		if (halted_q) begin
			pend_valid_n = 1'b0;
		end else if (pend_valid_q) begin
			seq[0]       = u16u8_pkg::LEAD_FOUR | {5'b0, val[20:18]};
			seq[1]       = u16u8_pkg::CONT_MARK | {2'b0, val[17:12]};
			seq[2]       = u16u8_pkg::CONT_MARK | {2'b0, val[11:6]};
			seq[3]       = u16u8_pkg::CONT_MARK | {2'b0, val[5:0]};
			len          = 3'd4;
			units        = 2'd2;
			pend_valid_n = 1'b0;
			pend_bits_n  = '0;
		end else if ((unit & u16u8_pkg::MASK_ONE_BYTE) == 16'h0000) begin
			seq[0] = unit[7:0];
			len    = 3'd1;
		end else if ((unit & u16u8_pkg::MASK_TWO_BYTE) == 16'h0000) begin
			seq[0] = u16u8_pkg::LEAD_TWO | {3'b0, unit[10:6]};
			seq[1] = u16u8_pkg::CONT_MARK | {2'b0, unit[5:0]};
			len    = 3'd2;
		end else if ((unit & u16u8_pkg::MASK_SURR) != u16u8_pkg::HIGH_SURR_BASE) begin
			seq[0] = u16u8_pkg::LEAD_THREE | {4'b0, unit[15:12]};
			seq[1] = u16u8_pkg::CONT_MARK | {2'b0, unit[11:6]};
			seq[2] = u16u8_pkg::CONT_MARK | {2'b0, unit[5:0]};
			len    = 3'd3;
		end else if (!last) begin
			pend_bits_n  = unit[9:0];
			pend_valid_n = 1'b1;
		end

		// capacity and unit cap check
		dst_sum  = {1'b0, dst_q} + {8'b0, len};
		unit_sum = {3'b0, src_q[10:1]} + {11'b0, units};
		no_room  = (dst_sum > {1'b0, limit}) ||
			(unit_sum > 13'(u16u8_pkg::MAX_UNITS));

		if (len != 3'd0) begin
			if (no_room) begin
				halted_n = 1'b1;
				len      = 3'd0;
			end else begin
				dst_n = dst_sum[9:0];
				src_n = src_q + {8'b0, units, 1'b0};
			end
		end

		bundle.seq     = seq;
		bundle.nbytes  = len;
		bundle.summary = last;
		bundle.src     = src_n;
		bundle.dst     = dst_n;
		bundle.status  = (dst_n == 10'd0);
		has_results    = (len != 3'd0) || last;

		// end of string returns the state to its reset values
		if (last) begin
			pend_bits_n  = '0;
			pend_valid_n = 1'b0;
			src_n        = '0;
			dst_n        = '0;
			halted_n     = 1'b0;
		end
	end

	// per-string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q  <= '0;
			pend_valid_q <= 1'b0;
			src_q        <= '0;
			dst_q        <= '0;
			halted_q     <= 1'b0;
		end else if (fire) begin
			pend_bits_q  <= pend_bits_n;
			pend_valid_q <= pend_valid_n;
			src_q        <= src_n;
			dst_q        <= dst_n;
			halted_q     <= halted_n;
		end
	end

endmodule

@@ rtl/core/u16u8_emit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u16u8_emit
// Result register holding one bundle and the serializer that presents its
// bytes and summary one request per cycle while out_ready is high.
// ---------------------------------------------------------------------------
module u16u8_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  u16u8_pkg::bundle_t bundle,
	output logic               can_load,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         utf8_byte,
	output logic               is_summary,
	output logic               run_end,
	output logic [10:0]        source_bytes_used,
	output logic [9:0]         bytes_written,
	output logic               status
);

	u16u8_pkg::bundle_t bundle_s2;
	logic               valid_s2;
	logic [2:0]         idx_q;
	logic [2:0]         total;
	logic               in_bytes;
	logic               done;

	assign total     = bundle_s2.nbytes + {2'b0, bundle_s2.summary};
	assign in_bytes  = idx_q < bundle_s2.nbytes;
	assign run_end   = (idx_q == total - 3'd1);
	assign out_valid = valid_s2;
	assign done      = valid_s2 && out_ready && run_end;
	assign can_load  = !valid_s2 || done;

	// current result selection
	always_comb begin
		if (in_bytes) begin
			utf8_byte         = bundle_s2.seq[idx_q[1:0]];
			is_summary        = 1'b0;
			source_bytes_used = '0;
			bytes_written     = '0;
			status            = 1'b0;
		end else begin
			utf8_byte         = '0;
			is_summary        = 1'b1;
			source_bytes_used = bundle_s2.src;
			bytes_written     = bundle_s2.dst;
			status            = bundle_s2.status;
		end
	end

	// bundle payload
	always_ff @(posedge clk) begin
		if (load) begin
			bundle_s2 <= bundle;
		end
	end

	// serializer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (done) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (valid_s2 && out_ready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

endmodule

@@ rtl/core/utf16be_to_utf8_transcoder.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf16be_to_utf8_transcoder
// Converts big-endian UTF-16 code units to UTF-8 bytes with a per-string
// byte limit and an end-of-string summary.
// ---------------------------------------------------------------------------
// channel | handshake            | payload
// in      | in_valid / in_ready  | code_unit, last_unit
// out     | out_valid / out_ready| utf8_byte, is_summary, run_end,
//         |                      | source_bytes_used, bytes_written, status
// cfg     | cfg_valid / cfg_ready| cfg_byte_limit
//
// A unit is registered on accept, then encoded and loaded into the result
// register once that register can take it; its first result is offered
// as soon as it is loaded.
// The byte-wide output port presents a unit's results one at a time, up to 5
// (four bytes and a summary); a unit with no result skips the result register.
// Input is taken while the result register drains; stalls on out only back
// up once both the input and result registers are full.
// Reset clears all string state and sets the byte limit to 510.
// ---------------------------------------------------------------------------
module utf16be_to_utf8_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  utf8_byte,
	output logic        is_summary,
	output logic        run_end,
	output logic [10:0] source_bytes_used,
	output logic [9:0]  bytes_written,
	output logic        status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_byte_limit
);

	logic               valid_s1;
	logic [15:0]        unit_s1;
	logic               last_s1;
	logic [9:0]         limit_q;
	u16u8_pkg::bundle_t bundle;
	logic               has_results;
	logic               can_load;
	logic               fire;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && (!has_results || can_load);
	assign in_ready  = !valid_s1 || fire;

	// byte limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= u16u8_pkg::BYTE_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_byte_limit;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			unit_s1 <= code_unit;
			last_s1 <= last_unit;
		end
	end

	u16u8_encode u_encode (
		.clk         (clk),
		.arst_n      (arst_n),
		.unit        (unit_s1),
		.last        (last_s1),
		.fire        (fire),
		.limit       (limit_q),
		.bundle      (bundle),
		.has_results (has_results)
	);

	u16u8_emit u_emit (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (fire && has_results),
		.bundle            (bundle),
		.can_load          (can_load),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.utf8_byte         (utf8_byte),
		.is_summary        (is_summary),
		.run_end           (run_end),
		.source_bytes_used (source_bytes_used),
		.bytes_written     (bytes_written),
		.status            (status)
	);

endmodule

@@ rtl/core/u16u8_chk.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u16u8_chk
// Port-level checks on the transcoder's result channel.
// ---------------------------------------------------------------------------
module u16u8_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  utf8_byte,
	input logic        is_summary,
	input logic        run_end,
	input logic [10:0] source_bytes_used,
	input logic [9:0]  bytes_written,
	input logic        status
);

	// stalled request holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(utf8_byte) &&
		$stable(is_summary) && $stable(run_end))
		else $error("result changed while stalled");

	// summary closes its unit's run
	a_summary_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_summary |-> run_end)
		else $error("summary without run_end");

	// byte results carry no counts
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_summary |-> source_bytes_used == 11'd0 &&
		bytes_written == 10'd0 && !status)
		else $error("byte result with counts");

	// status flags an empty string
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_summary |-> status == (bytes_written == 10'd0))
		else $error("summary status mismatch");

	// source bytes come in whole units and summaries carry a zero byte
	a_src_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_summary |-> !source_bytes_used[0] && utf8_byte == 8'd0)
		else $error("odd source byte count");

endmodule

bind utf16be_to_utf8_transcoder u16u8_chk u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.utf8_byte         (utf8_byte),
	.is_summary        (is_summary),
	.run_end           (run_end),
	.source_bytes_used (source_bytes_used),
	.bytes_written     (bytes_written),
	.status            (status)
);
